### rtl/pli_pkg.sv
// Shared constants, codes and channel types of the piecewise linear interpolator
package pli_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 6;
    localparam int CFG_W       = 7;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    // entries_in_use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;

    // request function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // result region codes
    typedef enum logic [1:0] {
        REGION_INTERIOR = 2'd0,
        REGION_BELOW    = 2'd1,
        REGION_ABOVE    = 2'd2,
        REGION_LOAD     = 2'd3
    } t_region;

    // input request
    typedef struct packed {
        logic                     func;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] y_value;
    } t_in;

    // result request
    typedef struct packed {
        logic signed [DATA_W-1:0] y_result;
        logic [1:0]               region;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic scan;
        logic setup;
        logic mul;
        logic div;
        logic finish;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic first;
        logic last_entry;
        logic div_last;
    } t_status;

endpackage

### rtl/pli_ram.sv
// Generic simple dual-port RAM with registered read
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pli_datapath.sv
// Datapath: breakpoint tables, scan, multiply, divide and result registers
module pli_datapath import pli_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_in              i_in_data,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output t_out             o_out_data
);

    // configuration and effective count
    logic [CFG_W-1:0] r_entries;
    logic [CNT_W-1:0] eff_count;

    // scan state
    logic signed [DATA_W-1:0] r_xq;
    logic [CNT_W-1:0]         r_n;
    logic [CNT_W-1:0]         r_addr;
    logic [CNT_W-1:0]         r_cmp_idx;
    logic                     r_cmp_valid;
    logic                     issue;
    logic                     cmp_valid;
    logic                     gt;

    // table ports
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [DATA_W-1:0]        x_rd;
    logic [DATA_W-1:0]        y_rd;

    // bracketing breakpoints
    logic [DATA_W-1:0] r_x0, r_y0, r_x1, r_y1;

    // arithmetic
    logic [DATA_W:0]     diff_t, diff_x, diff_y, neg_y;
    logic [DATA_W-1:0]   r_t, r_dx, r_ady;
    logic                r_neg;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W-1:0]   r_rem, r_quo;
    logic [DATA_W:0]     rem_sh, rem_sub;
    logic                geq;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // results
    t_out r_res;
    t_out r_out;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_entries <= i_cfg_data;
        end
    end

    // clamp the count into 1..depth
    always_comb begin
        if (r_entries == '0) begin
            eff_count = CNT_W'(1);
        end else if (32'(r_entries) > TABLE_DEPTH) begin
            eff_count = CNT_W'(TABLE_DEPTH);
        end else begin
            eff_count = CNT_W'(r_entries);
        end
    end

    // table write on load
    assign we    = i_cmd.load && (32'(i_in_data.entry_index) < TABLE_DEPTH);
    assign waddr = ADDR_W'(i_in_data.entry_index);
    assign issue = i_cmd.scan && (r_addr < r_n);

    pli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_in_data.x_value),
        .i_re    (issue),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (x_rd)
    );

    pli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_in_data.y_value),
        .i_re    (issue),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (y_rd)
    );

    // compare pipeline valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else if (i_cmd.start) begin
            r_cmp_valid <= 1'b0;
        end else begin
            r_cmp_valid <= issue;
        end
    end

    // scan address and query point
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_xq   <= i_in_data.x_value;
            r_n    <= eff_count;
            r_addr <= '0;
        end else if (issue) begin
            r_addr    <= r_addr + CNT_W'(1);
            r_cmp_idx <= r_addr;
        end
    end

    // compare the entry read last cycle
    assign cmp_valid = i_cmd.scan && r_cmp_valid;
    assign gt        = $signed(x_rd) > r_xq;

    assign o_status.hit        = cmp_valid && gt;
    assign o_status.first      = (r_cmp_idx == '0);
    assign o_status.last_entry = cmp_valid && !gt && (r_cmp_idx == r_n - CNT_W'(1));
    assign o_status.div_last   = i_cmd.div && (r_div_cnt == '1);

    // keep the entries around the query
    always_ff @(posedge i_clk) begin
        if (cmp_valid && !gt) begin
            r_x0 <= x_rd;
            r_y0 <= y_rd;
        end
        if (cmp_valid && gt) begin
            r_x1 <= x_rd;
            r_y1 <= y_rd;
        end
    end

    // offsets and slope magnitude
    assign diff_t = {r_xq[DATA_W-1], r_xq} - {r_x0[DATA_W-1], r_x0};
    assign diff_x = {r_x1[DATA_W-1], r_x1} - {r_x0[DATA_W-1], r_x0};
    assign diff_y = {r_y1[DATA_W-1], r_y1} - {r_y0[DATA_W-1], r_y0};
    assign neg_y  = -diff_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_t   <= diff_t[DATA_W-1:0];
            r_dx  <= diff_x[DATA_W-1:0];
            r_neg <= diff_y[DATA_W];
            r_ady <= diff_y[DATA_W] ? neg_y[DATA_W-1:0] : diff_y[DATA_W-1:0];
        end
    end

    // product and restoring division, one quotient bit a cycle
    assign prod    = r_t * r_ady;
    assign rem_sh  = {r_rem, r_quo[DATA_W-1]};
    assign geq     = rem_sh >= {1'b0, r_dx};
    assign rem_sub = rem_sh - {1'b0, r_dx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_rem     <= prod[2*DATA_W-1:DATA_W];
            r_quo     <= prod[DATA_W-1:0];
            r_div_cnt <= '0;
        end else if (i_cmd.div) begin
            r_rem     <= geq ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            r_quo     <= {r_quo[DATA_W-2:0], geq};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    // result selection
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res.y_result <= '0;
            r_res.region   <= REGION_LOAD;
        end else if (o_status.hit && o_status.first) begin
            r_res.y_result <= y_rd;
            r_res.region   <= REGION_BELOW;
        end else if (o_status.last_entry) begin
            r_res.y_result <= y_rd;
            r_res.region   <= REGION_ABOVE;
        end else if (i_cmd.finish) begin
            r_res.y_result <= r_neg ? r_y0 - r_quo : r_y0 + r_quo;
            r_res.region   <= REGION_INTERIOR;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_data = r_out;

endmodule

### rtl/pli_controller.sv
// Controller: sequences load, scan, multiply and divide, owns the handshakes
module pli_controller import pli_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_func,
    input  logic    i_out_stall,
    input  t_status i_status,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_SETUP  = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_FINISH = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == FUNC_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                priority if (i_status.hit && i_status.first) begin
                    n_state = ST_DONE;
                end else if (i_status.hit) begin
                    n_state = ST_SETUP;
                end else if (i_status.last_entry) begin
                    n_state = ST_DONE;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // input taken only when idle and out of reset
    assign o_in_stall  = (r_state != ST_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;

endmodule

### rtl/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries load and query
// requests. A load writes one breakpoint (x, y) and answers region 3 with a
// zero value. A query scans the breakpoints in use from entry 0, one table
// read per cycle on the x and y memories, up to the first x above the query.
// An interior hit then passes through a setup step, a 32x32 multiply and a
// restoring division before the result is formed.
// The scan stops at an entry index of at most 63 for a 64-entry table. One
// request is in work at a time and the next is taken in the cycle after the
// result is loaded.
// The result request sits in an output register (o_out_valid / i_out_stall /
// o_out_data); the next request is accepted while it waits, and its result
// is held back until the register is free.
// The user writes entries_in_use over the configuration channel only while
// the block is idle; the block does not enforce this. Reset sets it to 2,
// empties the output register and leaves the tables undefined until loaded.
module piecewise_linear_interpolator import pli_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    logic    in_acc;

    assign o_cfg_ready = i_rst_n;
    assign in_acc      = i_in_valid && !o_in_stall;

    pli_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_in_data.func),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    pli_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

    // an accepted request blocks the input until it is done
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after a request was taken");

    // a new result appears only through an output load
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.out_load))
        else $error("result valid without an output load");

    // the controller issues at most one command a cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.start, cmd.scan, cmd.setup,
                  cmd.mul, cmd.div, cmd.finish, cmd.out_load}))
        else $error("more than one datapath command at once");

    // a scan hit is only reported while scanning
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.hit || status.last_entry) |-> cmd.scan)
        else $error("scan status outside the scan");

endmodule
